[rtl/core/awp_pkg.sv]
// awp_pkg: shared types and constants for the adaptive window pacer
// no dependencies
`timescale 1ns / 1ps
package awp_pkg;
  localparam int unsigned MaxWindow = 1024;
  localparam int unsigned QAw = $clog2(MaxWindow);
  localparam int unsigned WinW = QAw + 1;
  localparam int unsigned TimeW = 48;
  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_NO_SLOT  = 3'd1,
    ST_DRAINING = 3'd2,
    ST_ENDED    = 3'd3,
    ST_NO_OUT   = 3'd4
  } status_t;

  typedef enum logic [AddrW-1:0] {
    REG_MODE    = 5'd0,
    REG_RATE    = 5'd4,
    REG_LIMIT   = 5'd8,
    REG_CAP     = 5'd12,
    REG_SAMPLES = 5'd16
  } reg_addr_t;

  typedef enum logic [3:0] {
    S_IDLE, S_END_RD, S_END_WAIT, S_END_UPD, S_REQ_CHK, S_DIV_AVG, S_ADJ,
    S_DRAIN, S_REQ_DEC, S_MUL, S_DIV_EXP, S_GRANT, S_OUT
  } state_t;
endpackage

[rtl/core/awp_if.sv]
// awp_if: valid/ready channel carrying one payload word
// depends on nothing
`timescale 1ns / 1ps
interface awp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/awp_ram.sv]
// awp_ram: generic single-port write, single-port registered read memory
// no dependencies
`timescale 1ns / 1ps
module awp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/adaptive_window_pacer_core.sv]
// adaptive_window_pacer_core: window pacer with serial divider and start-time queue
// depends on awp_pkg, awp_if, awp_ram
// a completion word passes S_END_RD, S_END_WAIT and S_END_UPD, a request word S_END_RD, S_REQ_CHK,
//   S_DRAIN, S_REQ_DEC and S_GRANT with at most one 64-step division (search step or pacing delay)
// one word at a time: next word taken in idle once the result has left, unless a write holds it off
// reset: rst synchronous active high; state and config registers reset, queue memory is not cleared
`timescale 1ns / 1ps
module adaptive_window_pacer_core
  import awp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  awp_if.sink         in_ch,
  awp_if.source       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // config registers
  logic [1:0]  mode;
  logic [31:0] max_rate, latency_limit_us;
  logic [WinW-1:0] window_cap;
  logic [15:0] samples_per_window;

  // pacer state
  logic [WinW-1:0] lower_bound, upper_bound, window, outstanding;
  logic [31:0] sent_in_window, ends_in_window, end_credit;
  logic [63:0] latency_total;
  logic [TimeW-1:0] window_begin;
  logic drain_pending;
  logic [QAw-1:0] queue_head;

  // captured input word
  logic kind;
  logic [TimeW-1:0] now_us;

  // shared divider: quot/rem over 64 steps
  logic [63:0] dquot;
  logic [63:0] drem;
  logic [31:0] ddiv;
  logic [6:0]  dcnt;
  logic [64:0] dtrial;
  logic [63:0] mul_res;

  status_t     res_status;
  logic [31:0] res_delay;

  state_t state, state_next;

  logic cfg_wr;
  logic cfg_hit;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && cfg_hit;

  // only writes to a real register touch the pacer
  always_comb begin
    unique case (paddr)
      REG_MODE, REG_RATE, REG_LIMIT, REG_CAP, REG_SAMPLES: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  // bound reload values after a config write, derived from the clamped cap and mode
  logic [WinW-1:0] cap_c;
  logic [1:0] mode_c;
  always_comb begin
    cap_c = (window_cap == '0) ? WinW'(1)
          : (window_cap > WinW'(MaxWindow)) ? WinW'(MaxWindow) : window_cap;
    mode_c = (mode == 2'd3) ? 2'd0 : mode;
  end

  always_comb begin
    unique case (paddr)
      REG_MODE:    prdata = {30'd0, mode};
      REG_RATE:    prdata = max_rate;
      REG_LIMIT:   prdata = latency_limit_us;
      REG_CAP:     prdata = {{(32-WinW){1'b0}}, window_cap};
      REG_SAMPLES: prdata = {16'd0, samples_per_window};
      default:     prdata = '0;
    endcase
  end

  // queue memory: start times of outstanding sends
  logic ram_we;
  logic [QAw-1:0] ram_waddr;
  logic [TimeW-1:0] ram_wdata, ram_rdata;
  awp_ram #(.Width(TimeW), .Depth(MaxWindow)) u_queue (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(queue_head), .rdata(ram_rdata)
  );

  // restoring division step
  assign dtrial = {drem, dquot[63]} - {33'd0, ddiv};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_ch.valid) state_next = S_END_RD;
      S_END_RD:   state_next = kind ? S_END_WAIT : S_REQ_CHK;
      S_END_WAIT: state_next = S_END_UPD;
      S_END_UPD:  state_next = S_OUT;
      S_REQ_CHK:  state_next = (!drain_pending && upper_bound > lower_bound &&
                                ends_in_window >= {16'd0, samples_per_window == 16'd0 ?
                                16'd1 : samples_per_window}) ? S_DIV_AVG : S_DRAIN;
      S_DIV_AVG:  if (dcnt == 7'd0) state_next = S_ADJ;
      S_ADJ:      state_next = S_DRAIN;
      S_DRAIN:    state_next = S_REQ_DEC;
      S_REQ_DEC:  state_next = (drain_pending || outstanding >= window || sent_in_window == '0)
                               ? S_GRANT : S_MUL;
      S_MUL:      state_next = S_DIV_EXP;
      S_DIV_EXP:  if (dcnt == 7'd0) state_next = S_GRANT;
      S_GRANT:    state_next = S_OUT;
      S_OUT:      if (out_ch.ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    // no word taken while a register write is in its access cycle
    in_ch.ready          = (state == S_IDLE) && !cfg_wr;
    out_ch.valid         = (state == S_OUT);
    out_ch.data.status   = res_status;
    out_ch.data.delay_us = res_delay;
    out_ch.data.converged = (upper_bound <= lower_bound);
    out_ch.data.window_size = window;
    ram_we    = (state == S_GRANT) && !drain_pending && (outstanding < window);
    ram_waddr = queue_head + outstanding[QAw-1:0];
  end

  logic [TimeW-1:0] elapsed;
  logic [63:0] start_w;
  logic [63:0] dly64;
  assign elapsed = now_us - window_begin;
  always_comb begin
    dly64 = (dquot > {16'd0, elapsed}) ? dquot - {16'd0, elapsed} : 64'd0;
    start_w = (dly64 > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : dly64;
  end
  assign ram_wdata = (sent_in_window == '0) ? now_us : now_us + start_w[TimeW-1:0];

  logic [TimeW-1:0] lat;
  assign lat = now_us - ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= '0; max_rate <= 32'd1000000; latency_limit_us <= 32'd1000;
      window_cap <= WinW'(64); samples_per_window <= 16'd100;
      lower_bound <= WinW'(1); upper_bound <= WinW'(64); window <= WinW'(32);
      outstanding <= '0; sent_in_window <= '0; ends_in_window <= '0;
      end_credit <= '0; latency_total <= '0; window_begin <= '0;
      drain_pending <= 1'b0; queue_head <= '0;
    end else if (cfg_wr) begin
      // store register and clear pacer state; bounds reinit later via the zero upper bound marker
      unique case (paddr)
        REG_MODE:    mode <= pwdata[1:0];
        REG_RATE:    max_rate <= pwdata;
        REG_LIMIT:   latency_limit_us <= pwdata;
        REG_CAP:     window_cap <= pwdata[WinW-1:0];
        REG_SAMPLES: samples_per_window <= pwdata[15:0];
        default: ;
      endcase
      outstanding <= '0; sent_in_window <= '0; ends_in_window <= '0;
      end_credit <= '0; latency_total <= '0; window_begin <= '0;
      drain_pending <= 1'b0; queue_head <= '0;
      // bounds reloaded in the first cycle with no register write
      lower_bound <= '0; upper_bound <= '0;
    end else begin
      state <= state_next;
      // bounds reload after a config write (marked by zero upper bound)
      if (upper_bound == '0) begin
        lower_bound <= (mode_c != 2'd0) ? cap_c : WinW'(1);
        upper_bound <= cap_c;
        window <= (mode_c == 2'd2) ? cap_c : WinW'((cap_c + WinW'(1)) >> 1);
      end
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          kind <= in_ch.data.kind;
          now_us <= in_ch.data.now_us;
        end
        S_END_RD: ;
        S_END_WAIT: ;
        S_END_UPD: begin
          if (outstanding == '0) res_status <= ST_NO_OUT;
          else begin
            res_status <= ST_ENDED;
            latency_total <= (latency_total > ~{16'd0, lat}) ? '1
                             : latency_total + {16'd0, lat};
            queue_head <= queue_head + QAw'(1);
            outstanding <= outstanding - WinW'(1);
            if (ends_in_window != '1) ends_in_window <= ends_in_window + 32'd1;
            if (end_credit != '1) end_credit <= end_credit + 32'd1;
          end
          res_delay <= '0;
        end
        S_REQ_CHK: begin
          dquot <= latency_total; drem <= '0; ddiv <= ends_in_window; dcnt <= 7'd64;
        end
        S_DIV_AVG, S_DIV_EXP: if (dcnt != 7'd0) begin
          if (!dtrial[64]) begin
            drem <= dtrial[63:0]; dquot <= {dquot[62:0], 1'b1};
          end else begin
            drem <= {drem[62:0], dquot[63]}; dquot <= {dquot[62:0], 1'b0};
          end
          dcnt <= dcnt - 7'd1;
        end
        S_ADJ: begin
          if (dquot > {32'd0, latency_limit_us}) begin
            upper_bound <= window;
            window <= lower_bound + ((window - lower_bound) >> 1);
          end else begin
            lower_bound <= window + WinW'(1);
            window <= window + WinW'(1) + ((upper_bound - window - WinW'(1)) >> 1);
          end
          drain_pending <= 1'b1;
        end
        S_DRAIN: if (drain_pending) begin
          if (end_credit >= sent_in_window) begin
            end_credit <= end_credit - sent_in_window;
            sent_in_window <= '0;
            drain_pending <= 1'b0;
            ends_in_window <= '0;
            latency_total <= '0;
          end else begin
            sent_in_window <= sent_in_window - end_credit;
            end_credit <= '0;
          end
        end
        S_REQ_DEC: begin
          mul_res <= sent_in_window * 64'd1000000;
          dquot <= '0;
        end
        S_MUL: begin
          dquot <= mul_res; drem <= '0; dcnt <= 7'd64;
          ddiv <= (max_rate == '0) ? 32'd1 : max_rate;
        end
        S_GRANT: begin
          res_delay <= '0;
          if (drain_pending) res_status <= ST_DRAINING;
          else if (outstanding >= window) res_status <= ST_NO_SLOT;
          else begin
            res_status <= ST_GRANTED;
            if (sent_in_window == '0) window_begin <= now_us;
            else res_delay <= start_w[31:0];
            if (sent_in_window != '1) sent_in_window <= sent_in_window + 32'd1;
            outstanding <= outstanding + WinW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/core/awp_checker.sv]
// awp_checker: port-level assertions for the pacer core
// depends on awp_pkg, bound into adaptive_window_pacer_core
`timescale 1ns / 1ps
module awp_checker
  import awp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] status,
  input logic [31:0] delay_us,
  input logic [WinW-1:0] window_size
);
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_delay_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_GRANTED |-> delay_us == '0) else $error("delay on refusal");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_NO_OUT) else $error("bad status");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
  a_window_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_size != '0 && window_size <= WinW'(MaxWindow))
    else $error("window out of range");
endmodule

bind adaptive_window_pacer_core awp_checker u_awp_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.data.status),
  .delay_us(out_ch.data.delay_us), .window_size(out_ch.data.window_size)
);

[tb/tb_awp_types.sv]
// tb_awp_types: word layouts of the pacer's event and result channels
// depends on awp_pkg
`timescale 1ns / 1ps
package tb_awp_types;
  import awp_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [TimeW-1:0] now_us;
  } event_word_t;

  typedef struct packed {
    status_t         status;
    logic [31:0]     delay_us;
    logic            converged;
    logic [WinW-1:0] window_size;
  } result_word_t;
endpackage

[tb/tb_adaptive_window_pacer_core.sv]
// tb_adaptive_window_pacer_core: self-checking bench for the window pacer core
// drives request and completion words, predicts every result, checks in order
// depends on awp_pkg, awp_if, tb_awp_types and the core rtl
`timescale 1ns / 1ps
module tb_adaptive_window_pacer_core;
  import awp_pkg::*;
  import tb_awp_types::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  awp_if #(.payload_t(event_word_t)) in_ch ();
  awp_if #(.payload_t(result_word_t)) out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  adaptive_window_pacer_core i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies held by the predictor
  logic [1:0]  cfg_mode;
  logic [31:0] cfg_rate;
  logic [31:0] cfg_limit;
  logic [10:0] cfg_cap;
  logic [15:0] cfg_samples;

  // predicted pacer state
  logic [63:0] lower_b, upper_b, win, inflight;
  logic [63:0] sent_cnt, end_cnt, credit, lat_sum;
  logic [TimeW-1:0] win_start;
  logic [QAw-1:0] head;
  logic draining;
  logic [TimeW-1:0] start_times [MaxWindow];

  result_word_t expected_results [$];
  int errors = 0;
  logic [TimeW-1:0] clock_us = '0;
  int burst_left = 0;
  bit stall_req = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // reload state from the register copies, as after reset or any write
  function automatic void restart_pacer();
    logic [63:0] c;
    logic [1:0] m;
    c = cfg_cap;
    m = (cfg_mode == 2'd3) ? 2'd0 : cfg_mode;
    if (c < 1) c = 1;
    if (c > MaxWindow) c = MaxWindow;
    lower_b = (m != 0) ? c : 64'd1;
    upper_b = c;
    win = (m == 2) ? c : (c + 1) / 2;
    inflight = 0; sent_cnt = 0; end_cnt = 0; credit = 0; lat_sum = 0;
    win_start = '0; head = '0; draining = 1'b0;
  endfunction

  function automatic logic [63:0] sat32_inc(input logic [63:0] v);
    return (v < 64'hFFFF_FFFF) ? v + 1 : 64'hFFFF_FFFF;
  endfunction

  function automatic result_word_t pace_event(input logic kind, input logic [TimeW-1:0] now);
    result_word_t r;
    logic [63:0] lat, need, avg, rate, elapsed, target, dly, take;
    r = '0;
    dly = 0;
    if (kind) begin
      if (inflight == 0) begin
        r.status = ST_NO_OUT;
      end else begin
        lat = {16'd0, now - start_times[head]};
        lat_sum = (lat_sum > ~64'd0 - lat) ? ~64'd0 : lat_sum + lat;
        head = head + 1'b1;
        inflight = inflight - 1;
        end_cnt = sat32_inc(end_cnt);
        credit = sat32_inc(credit);
        r.status = ST_ENDED;
      end
    end else begin
      need = (cfg_samples != 0) ? cfg_samples : 64'd1;
      // binary search step once enough completions are in
      if (!draining && upper_b > lower_b && end_cnt >= need) begin
        avg = lat_sum / end_cnt;
        if (avg > cfg_limit) upper_b = win;
        else lower_b = win + 1;
        win = lower_b + (upper_b - lower_b) / 2;
        draining = 1'b1;
      end
      if (draining) begin
        take = (credit < sent_cnt) ? credit : sent_cnt;
        credit = credit - take;
        sent_cnt = sent_cnt - take;
        if (sent_cnt == 0) begin
          draining = 1'b0;
          end_cnt = 0;
          lat_sum = 0;
        end
      end
      if (draining) begin
        r.status = ST_DRAINING;
      end else if (inflight >= win) begin
        r.status = ST_NO_SLOT;
      end else begin
        if (sent_cnt == 0) begin
          win_start = now;
        end else begin
          rate = (cfg_rate != 0) ? cfg_rate : 64'd1;
          elapsed = {16'd0, now - win_start};
          target = sent_cnt * 64'd1000000 / rate;
          if (target > elapsed) dly = target - elapsed;
          if (dly > 64'hFFFF_FFFF) dly = 64'hFFFF_FFFF;
        end
        sent_cnt = sat32_inc(sent_cnt);
        start_times[head + inflight[QAw-1:0]] = now + dly[TimeW-1:0];
        inflight = inflight + 1;
        r.status = ST_GRANTED;
      end
    end
    r.delay_us = dly[31:0];
    r.converged = (upper_b <= lower_b);
    r.window_size = win[WinW-1:0];
    return r;
  endfunction

  // one word to the block, bursts and gaps drawn at random
  task automatic send_word(input logic kind, input logic [TimeW-1:0] now);
    event_word_t w;
    w.kind = kind;
    w.now_us = now;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(pace_event(kind, now));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // quiet margin before any register access
    repeat (160) @(posedge clk);
  endtask

  task automatic write_reg(input reg_addr_t addr, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      REG_MODE:    cfg_mode = value[1:0];
      REG_RATE:    cfg_rate = value;
      REG_LIMIT:   cfg_limit = value;
      REG_CAP:     cfg_cap = value[10:0];
      REG_SAMPLES: cfg_samples = value[15:0];
      default: ;
    endcase
    restart_pacer();
    @(posedge clk);
  endtask

  task automatic read_reg(input reg_addr_t addr, input logic [31:0] want);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want || pready !== 1'b1)
      report($sformatf("register %0d reads %0h want %0h", addr, prdata, want));
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] m, input logic [31:0] rate,
                           input logic [31:0] lim, input logic [10:0] cap,
                           input logic [15:0] spw);
    wait_idle();
    write_reg(REG_MODE, {30'd0, m});
    write_reg(REG_RATE, rate);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_CAP, {21'd0, cap});
    write_reg(REG_SAMPLES, {16'd0, spw});
  endtask

  // time moves forward, wrapping at 2^48
  task automatic tick_and_send(input logic kind, input int unsigned step);
    clock_us = clock_us + step;
    send_word(kind, clock_us);
  endtask

  // mostly request/completion traffic that reaches the search, some noise
  task automatic run_traffic(input int n, input int unsigned max_step);
    int k;
    for (k = 0; k < n; k++) begin
      if (inflight != 0 && $urandom_range(0, 99) < 48)
        tick_and_send(1'b1, $urandom_range(0, max_step));
      else if ($urandom_range(0, 99) < 4)
        tick_and_send(1'b1, $urandom_range(0, max_step));
      else
        tick_and_send(1'b0, $urandom_range(0, max_step));
    end
  endtask

  task automatic test_defaults();
    // reset values, completion with nothing in flight first
    tick_and_send(1'b1, 3);
    tick_and_send(1'b0, 10);
    tick_and_send(1'b0, 0);
    tick_and_send(1'b1, 400);
    tick_and_send(1'b1, 5);
    tick_and_send(1'b1, 5);
  endtask

  task automatic test_readback();
    // every register reads back what was written
    configure(2'd1, 32'd12345, 32'd777, 11'd200, 16'd9);
    read_reg(REG_MODE, {30'd0, cfg_mode});
    read_reg(REG_RATE, cfg_rate);
    read_reg(REG_LIMIT, cfg_limit);
    read_reg(REG_CAP, {21'd0, cfg_cap});
    read_reg(REG_SAMPLES, {16'd0, cfg_samples});
  endtask

  task automatic test_register_edges();
    // zero rate, zero samples, zero cap, mode three
    configure(2'd3, 32'd0, 32'd0, 11'd0, 16'd0);
    tick_and_send(1'b0, 1); tick_and_send(1'b0, 1); tick_and_send(1'b1, 2);
    tick_and_send(1'b0, 3); tick_and_send(1'b1, 7); tick_and_send(1'b0, 9);
    // oversize cap clamps, fixed window, widest rate
    configure(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'h7FF, 16'hFFFF);
    tick_and_send(1'b0, 1); tick_and_send(1'b0, 0); tick_and_send(1'b1, 1);
    // time wrap near the top of the 48-bit range, slowest rate
    configure(2'd1, 32'd1, 32'd0, 11'd4, 16'd1);
    clock_us = 48'hFFFF_FFFF_FFF0;
    tick_and_send(1'b0, 1); tick_and_send(1'b0, 8); tick_and_send(1'b1, 20);
    tick_and_send(1'b0, 2); tick_and_send(1'b1, 3); tick_and_send(1'b0, 1);
    configure(2'd0, 32'd1, 32'd0, 11'd1024, 16'd1);
    tick_and_send(1'b0, 0); tick_and_send(1'b1, 50); tick_and_send(1'b0, 4);
  endtask

  task automatic test_random_search();
    int p;
    logic [31:0] rate;
    for (p = 0; p < 10; p++) begin
      case ($urandom_range(0, 3))
        0: rate = 1;
        1: rate = 1000;
        2: rate = 1000000;
        default: rate = $urandom;
      endcase
      configure(2'($urandom_range(0, 3)), rate, 32'($urandom_range(0, 3000)),
                ($urandom_range(0, 9) == 0) ? 11'd1024 : 11'($urandom_range(1, 40)),
                16'($urandom_range(1, 8)));
      if ($urandom_range(0, 2) == 0) clock_us = 48'({$urandom, $urandom});
      run_traffic(140, (p % 3 == 0) ? 6000 : 1500);
    end
  endtask

  task automatic test_backpressure();
    configure(2'd0, 32'd1000000, 32'd500, 11'd16, 16'd4);
    stall_req = 1'b1;
    run_traffic(120, 800);
  endtask

  // receiver: own stall pattern, one long hold-off on request
  initial begin
    int pat;
    pat = 0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        pat++;
        if ((pat / 64) % 2 == 0) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // result checker against the oldest prediction
  always @(posedge clk) begin
    result_word_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report("result with no prediction");
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        if (out_ch.data.status !== exp_r.status)
          report($sformatf("status %0d want %0d", out_ch.data.status, exp_r.status));
        if (out_ch.data.delay_us !== exp_r.delay_us)
          report($sformatf("delay %0d want %0d", out_ch.data.delay_us, exp_r.delay_us));
        if (out_ch.data.converged !== exp_r.converged)
          report($sformatf("converged %0b want %0b", out_ch.data.converged,
                           exp_r.converged));
        if (out_ch.data.window_size !== exp_r.window_size)
          report($sformatf("window %0d want %0d", out_ch.data.window_size,
                           exp_r.window_size));
      end
    end
  end

  initial begin
    #50ms;
    $display("FAIL adaptive_window_pacer_core");
    $finish;
  end

  initial begin
    cfg_mode = 2'd0; cfg_rate = 32'd1000000; cfg_limit = 32'd1000;
    cfg_cap = 11'd64; cfg_samples = 16'd100;
    restart_pacer();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (5) @(posedge clk);
    test_defaults();
    test_readback();
    test_register_edges();
    test_random_search();
    test_backpressure();
    wait_idle();
    if (errors == 0) $display("PASS adaptive_window_pacer_core");
    else $display("FAIL adaptive_window_pacer_core");
    $finish;
  end
endmodule

[filelist.f]
rtl/core/awp_pkg.sv
rtl/core/awp_if.sv
rtl/core/awp_ram.sv
rtl/core/adaptive_window_pacer_core.sv
rtl/core/awp_checker.sv
tb/tb_awp_types.sv
tb/tb_adaptive_window_pacer_core.sv
